// File: sv/rtpd_pkg.sv
// shared types, codes and constants of the h264 rtp depacketizer
package rtpd_pkg;

   localparam int FRAME_BYTES_WIDTH  = 24;
   localparam int PACKET_LEN_WIDTH   = 16;
   localparam int CSR_DATA_WIDTH     = 24;
   localparam int CSR_INDEX_WIDTH    = 1;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_FRAME_BYTES  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_PACKET_BYTES = 1'd1;

   localparam logic [FRAME_BYTES_WIDTH-1:0] MAX_FRAME_BYTES_RESET  = 24'd3000000;
   localparam logic [PACKET_LEN_WIDTH-1:0]  MAX_PACKET_BYTES_RESET = 16'd65535;

   // nal unit types
   localparam logic [4:0] NAL_UNIT_SINGLE_MIN = 5'd1;
   localparam logic [4:0] NAL_UNIT_SINGLE_MAX = 5'd23;
   localparam logic [4:0] NAL_UNIT_FU_A       = 5'd28;

   // annex b start code
   localparam logic [7:0] START_CODE_ZERO = 8'h00;
   localparam logic [7:0] START_CODE_ONE  = 8'h01;

   // position of the rebuilt nal header in a start code run
   localparam logic [1:0] PREFIX_LAST_INDEX = 2'd3;

   typedef enum logic [2:0] {
      MODE_DISCARD = 3'b001,
      MODE_SINGLE  = 3'b010,
      MODE_FUA     = 3'b100
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,   // one stream byte
      KIND_PREFIX = 2'd1,   // 00 00 01 then the header byte
      KIND_MARK   = 2'd2    // one result without a stream byte
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       frame_end;
      logic       dropped;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_slot_type;

endpackage

// File: sv/rtpd_front.sv
// front end: accepts payload bytes, tracks packet state and issues output jobs
module rtpd_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_stall,
   input  logic [7:0]                               req_payload_byte,
   input  logic                                     req_first_byte,
   input  logic                                     req_last_byte,
   input  logic                                     req_rtp_marker,
   input  logic [rtpd_pkg::PACKET_LEN_WIDTH-1:0]    req_packet_length,
   input  logic                                     csr_write_enable,
   input  logic [rtpd_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [rtpd_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data,
   output rtpd_pkg::job_slot_type                   push
);

   logic [rtpd_pkg::FRAME_BYTES_WIDTH-1:0] max_frame_ff;
   logic [rtpd_pkg::PACKET_LEN_WIDTH-1:0]  max_packet_ff;
   logic [rtpd_pkg::FRAME_BYTES_WIDTH-1:0] count_ff, count_in;
   rtpd_pkg::mode_type                     mode_ff, mode_in;
   logic                                   fu_hdr_ff, fu_hdr_in;
   logic [2:0]                             saved_ff, saved_in;

   logic                                   accept;
   logic [4:0]                             nal_code;
   logic                                   drop;
   logic [2:0]                             add;
   logic [rtpd_pkg::FRAME_BYTES_WIDTH:0]   count_sum;
   rtpd_pkg::job_slot_type                 slot;

   assign accept   = req_valid && !req_stall;
   assign nal_code = req_payload_byte[4:0];
   assign drop     = (count_ff > max_frame_ff) || (req_packet_length > max_packet_ff);

   always_comb begin
      mode_in   = mode_ff;
      fu_hdr_in = fu_hdr_ff;
      saved_in  = saved_ff;
      add       = 3'd0;
      slot      = '0;
      slot.job.kind = rtpd_pkg::KIND_BYTE;
      slot.job.data = req_payload_byte;

      if (req_first_byte) begin
         if (drop) begin
            slot.valid       = 1'b1;
            slot.job.kind    = rtpd_pkg::KIND_MARK;
            slot.job.data    = '0;
            slot.job.dropped = 1'b1;
            mode_in          = rtpd_pkg::MODE_DISCARD;
            fu_hdr_in        = 1'b0;
         end else if (nal_code >= rtpd_pkg::NAL_UNIT_SINGLE_MIN &&
                      nal_code <= rtpd_pkg::NAL_UNIT_SINGLE_MAX) begin
            slot.valid    = 1'b1;
            slot.job.kind = rtpd_pkg::KIND_PREFIX;
            add           = 3'd4;
            mode_in       = rtpd_pkg::MODE_SINGLE;
            fu_hdr_in     = 1'b0;
         end else if (nal_code == rtpd_pkg::NAL_UNIT_FU_A && !req_last_byte) begin
            mode_in   = rtpd_pkg::MODE_FUA;
            fu_hdr_in = 1'b1;
            saved_in  = req_payload_byte[7:5];
         end else begin
            mode_in   = rtpd_pkg::MODE_DISCARD;
            fu_hdr_in = 1'b0;
         end
      end else begin
         case (mode_ff)
            rtpd_pkg::MODE_SINGLE: begin
               slot.valid = 1'b1;
               add        = 3'd1;
            end
            rtpd_pkg::MODE_FUA: begin
               if (fu_hdr_ff) begin
                  // fu header: only a start fragment produces output
                  if (req_payload_byte[7]) begin
                     slot.valid    = 1'b1;
                     slot.job.kind = rtpd_pkg::KIND_PREFIX;
                     slot.job.data = {saved_ff, req_payload_byte[4:0]};
                     add           = 3'd4;
                  end
                  fu_hdr_in = 1'b0;
               end else begin
                  slot.valid = 1'b1;
                  add        = 3'd1;
               end
            end
            default: begin
            end
         endcase
      end

      count_sum = {1'b0, count_ff} + {{(rtpd_pkg::FRAME_BYTES_WIDTH-2){1'b0}}, add};
      if (count_sum[rtpd_pkg::FRAME_BYTES_WIDTH])
         count_in = '1;
      else
         count_in = count_sum[rtpd_pkg::FRAME_BYTES_WIDTH-1:0];

      if (req_first_byte && drop) begin
         count_in = '0;
      end else if (req_last_byte) begin
         if (req_rtp_marker && mode_in != rtpd_pkg::MODE_DISCARD) begin
            if (!slot.valid) begin
               slot.valid    = 1'b1;
               slot.job.kind = rtpd_pkg::KIND_MARK;
               slot.job.data = '0;
            end
            slot.job.frame_end = 1'b1;
            count_in           = '0;
         end
         mode_in   = rtpd_pkg::MODE_DISCARD;
         fu_hdr_in = 1'b0;
      end

      push       = slot;
      push.valid = slot.valid && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         mode_ff   <= rtpd_pkg::MODE_DISCARD;
         fu_hdr_ff <= 1'b0;
         saved_ff  <= '0;
      end else if (accept) begin
         count_ff  <= count_in;
         mode_ff   <= mode_in;
         fu_hdr_ff <= fu_hdr_in;
         saved_ff  <= saved_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff  <= rtpd_pkg::MAX_FRAME_BYTES_RESET;
         max_packet_ff <= rtpd_pkg::MAX_PACKET_BYTES_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rtpd_pkg::CSR_MAX_FRAME_BYTES:  max_frame_ff  <= csr_write_data;
            rtpd_pkg::CSR_MAX_PACKET_BYTES:
               max_packet_ff <= csr_write_data[rtpd_pkg::PACKET_LEN_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // a dropped packet leaves the front in discard mode with a cleared count
   a_drop_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && push.valid && push.job.dropped) |=>
         (mode_ff == rtpd_pkg::MODE_DISCARD && count_ff == '0))
      else $error("drop did not clear frame state");

endmodule

// File: sv/rtpd_queue.sv
// job queue between the front end and the output sequencer
module rtpd_queue #(
   parameter int QUEUE_DEPTH = rtpd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rtpd_pkg::job_slot_type push,
   input  logic                   pop,
   output rtpd_pkg::job_slot_type head,
   output logic                   full
);

   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   rtpd_pkg::job_type      slots_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == COUNT_WIDTH'(QUEUE_DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.job   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         slots_ff[wr_ptr_ff] <= push.job;
   end

   // the front never offers a job into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("job lost on full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

endmodule

// File: sv/rtpd_back.sv
// output sequencer: expands queued jobs into result transactions
module rtpd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  rtpd_pkg::job_slot_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_frame_end,
   output logic                   rsp_frame_dropped,
   output logic                   rsp_last_of_run
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvalid_ff, bvalid_in;
   logic       fend_ff, fend_in;
   logic       drop_ff, drop_in;
   logic       last_ff, last_in;
   logic       load, job_done;

   assign load     = head.valid && (!valid_ff || !rsp_stall);
   assign job_done = (head.job.kind != rtpd_pkg::KIND_PREFIX) ||
                     (idx_ff == rtpd_pkg::PREFIX_LAST_INDEX);
   assign pop      = load && job_done;

   always_comb begin
      idx_in = idx_ff;
      if (load)
         idx_in = job_done ? 2'd0 : idx_ff + 2'd1;

      valid_in = valid_ff;
      if (load)
         valid_in = 1'b1;
      else if (!rsp_stall)
         valid_in = 1'b0;

      bvalid_in = 1'b1;
      byte_in   = head.job.data;
      case (head.job.kind)
         rtpd_pkg::KIND_PREFIX: begin
            if (idx_ff == rtpd_pkg::PREFIX_LAST_INDEX)
               byte_in = head.job.data;
            else if (idx_ff == rtpd_pkg::PREFIX_LAST_INDEX - 2'd1)
               byte_in = rtpd_pkg::START_CODE_ONE;
            else
               byte_in = rtpd_pkg::START_CODE_ZERO;
         end
         rtpd_pkg::KIND_MARK: begin
            byte_in   = '0;
            bvalid_in = 1'b0;
         end
         default: begin
         end
      endcase
      fend_in = head.job.frame_end && job_done;
      drop_in = head.job.dropped;
      last_in = job_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         bvalid_ff <= bvalid_in;
         fend_ff   <= fend_in;
         drop_ff   <= drop_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_byte_valid    = bvalid_ff;
   assign rsp_frame_end     = fend_ff;
   assign rsp_frame_dropped = drop_ff;
   assign rsp_last_of_run   = last_ff;

   // mid-run position only while a start code job sits at the head
   a_idx_in_prefix: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> (head.valid && head.job.kind == rtpd_pkg::KIND_PREFIX))
      else $error("run index without prefix job");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && fend_ff) |-> last_ff)
      else $error("frame end before end of run");

   a_drop_no_byte: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && drop_ff) |-> (!bvalid_ff && last_ff && !fend_ff))
      else $error("malformed drop result");

endmodule

// File: sv/h264_rtp_depacketizer.sv
// top level of the h264 rtp depacketizer (rtp payload bytes to annex b stream)
//
//   channel  direction  handshake              carries
//   req_     in         req_valid / req_stall  one rtp payload byte with packet flags
//   rsp_     out        rsp_valid / rsp_stall  one annex b result per transaction
//   csr_     in         csr_write_enable       frame and packet length limits
//
// one input transaction per cycle is accepted whenever the job queue has room
// a single nal start or fu-a start fragment expands to four results (00 00 01 header),
// one per cycle from the output sequencer unless rsp_stall holds it; other jobs give one result
// the front end and the output sequencer are split by a QUEUE_DEPTH job queue,
// so a stalled output only backs up into req_stall once that queue is full
// synchronous active-high reset clears packet state and frame count and reloads the default limits
module h264_rtp_depacketizer #(
   parameter int QUEUE_DEPTH = rtpd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input byte channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_payload_byte,
   input  logic                                  req_first_byte,
   input  logic                                  req_last_byte,
   input  logic                                  req_rtp_marker,
   input  logic [rtpd_pkg::PACKET_LEN_WIDTH-1:0] req_packet_length,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_out_byte,
   output logic                                  rsp_byte_valid,
   output logic                                  rsp_frame_end,
   output logic                                  rsp_frame_dropped,
   output logic                                  rsp_last_of_run,
   // configuration writes
   input  logic                                  csr_write_enable,
   input  logic [rtpd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rtpd_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);

   rtpd_pkg::job_slot_type push;   // job from the front end, valid only on accept
   rtpd_pkg::job_slot_type head;   // oldest queued job
   logic                   pop;
   logic                   full;

   // input is held off only by a full job queue
   assign req_stall = full;

   rtpd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_payload_byte  (req_payload_byte),
      .req_first_byte    (req_first_byte),
      .req_last_byte     (req_last_byte),
      .req_rtp_marker    (req_rtp_marker),
      .req_packet_length (req_packet_length),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .push              (push)
   );

   // short queue decouples classification from result expansion
   rtpd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   // output register stage lives in the sequencer
   rtpd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_frame_dropped (rsp_frame_dropped),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
